FILE: rtl/least_squares_line_calibrator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the least-squares line calibrator
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LEAST_SQUARES_LINE_CALIBRATOR_DEFINES_SVH
`define LEAST_SQUARES_LINE_CALIBRATOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LSLC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LSLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LSLC_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define LSLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/lslc_pkg.sv
// ----------------------------------------------------------------------------
// Least-squares line calibrator package
// Word types, field widths, codes and sizing constants of the calibrator.
// ----------------------------------------------------------------------------
package lslc_pkg;

  // field and state widths
  localparam int ADC_W   = 12;
  localparam int REAL_W  = 32;
  localparam int GAIN_W  = 64;
  localparam int OFFS_W  = 32;
  localparam int TALLY_W = 8;
  localparam int SX_W    = 20;
  localparam int SY_W    = 40;
  localparam int SXY_W   = 52;
  localparam int SXX_W   = 32;
  localparam int SQ_W    = 2 * ADC_W;

  // most points summed in one session
  localparam int MAX_POINTS = 255;

  // digit-serial multiplier sizing
  localparam int DIGIT_W = 3;
  localparam int ACC_W   = 80;
  localparam int MPL_W   = 32;
  localparam int STEP_W  = 4;
  localparam int ADC_STEPS   = (ADC_W + DIGIT_W - 1) / DIGIT_W;
  localparam int TALLY_STEPS = (TALLY_W + DIGIT_W - 1) / DIGIT_W;
  localparam int SX_STEPS    = (SX_W + DIGIT_W - 1) / DIGIT_W;
  localparam int SXX_STEPS   = (SXX_W + DIGIT_W - 1) / DIGIT_W;

  // restoring divider sizing
  localparam int NUM_W  = 84;
  localparam int DEN_W  = 40;
  localparam int QR_W   = NUM_W + 1;
  localparam int CNT_W  = 7;
  localparam int FRAC_SHIFT = 24;   // Q23.40 gain against Q15.16 values

  // 1.0 in Q23.40
  localparam logic [GAIN_W-1:0] GAIN_ONE = 64'h0000_0100_0000_0000;

  // operation codes
  localparam logic OP_POINT = 1'b0;
  localparam logic OP_APPLY = 1'b1;

  // result kinds
  localparam logic KIND_FIT   = 1'b0;
  localparam logic KIND_APPLY = 1'b1;

  // fit status codes
  localparam logic [1:0] FIT_OK         = 2'd0;
  localparam logic [1:0] FIT_DEGENERATE = 2'd1;
  localparam logic [1:0] FIT_TOO_FEW    = 2'd2;

  typedef struct packed {
    logic                     op;
    logic [ADC_W-1:0]         adc_value;
    logic signed [REAL_W-1:0] real_value;
    logic                     last_point;
  } lslc_req_t;

  typedef struct packed {
    logic                     result_kind;
    logic signed [GAIN_W-1:0] fitted_gain;
    logic signed [OFFS_W-1:0] fitted_offset;
    logic [1:0]               fit_status;
    logic                     is_calibrated;
    logic signed [OFFS_W-1:0] converted_value;
  } lslc_rsp_t;

endpackage

FILE: rtl/least_squares_line_calibrator.sv
// ----------------------------------------------------------------------------
// Least-squares line calibrator
// A point word is multiplied and folded into the sums, or dropped if the tally is full;
// an apply word gives its result when the output is free, and req_stall holds off the
// next word until then. The point marked last starts a fit on the radix-8 serial
// multiplier and the two 84-step restoring divisions, then reports.
// Synchronous reset clears the sums and flag and loads gain 1.0, offset 0.
// ----------------------------------------------------------------------------
`include "least_squares_line_calibrator_defines.svh"

module least_squares_line_calibrator (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  lslc_pkg::lslc_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output lslc_pkg::lslc_rsp_t rsp
);
  import lslc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_PSUM, S_FIT, S_DEN, S_DCHK, S_GNUM, S_GMAG,
    S_ONUM, S_OMAG, S_AMAG, S_DIV, S_ROUND, S_SAT, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    TGT_GAIN, TGT_OFFSET, TGT_CONV
  } tgt_t;

  state_t state;
  state_t mul_ret;
  tgt_t   target;

  // session sums and fitted line
  logic [TALLY_W-1:0] point_tally;
  logic [SX_W-1:0]    sum_readings;
  logic [SY_W-1:0]    sum_true;
  logic [SXY_W-1:0]   sum_products;
  logic [SXX_W-1:0]   sum_squares;
  logic [GAIN_W-1:0]  gain_reg;
  logic [OFFS_W-1:0]  offset_reg;
  logic               calibrated_flag;

  // held word
  logic              kind_r;
  logic [ADC_W-1:0]  x_r;
  logic [REAL_W-1:0] y_r;
  logic              last_r;
  logic [1:0]        status_r;
  logic [OFFS_W-1:0] conv_r;

  // serial multiplier
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  mcand;
  logic [MPL_W-1:0]  mplier;
  logic [SQ_W-1:0]   sq_acc;
  logic [SQ_W-1:0]   sq_cand;
  logic [STEP_W-1:0] steps;

  // divider and rounding
  logic [NUM_W-1:0]  num_sh;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [CNT_W-1:0]  div_cnt;
  logic              neg_r;
  logic              rnd_r;
  logic [QR_W-1:0]   qr;

  logic [ACC_W-1:0]  pp;
  logic [ACC_W-1:0]  acc_step;
  logic [SQ_W-1:0]   sq_pp;
  logic [SQ_W-1:0]   sq_step;
  logic [ACC_W-1:0]  mag;
  logic [DEN_W:0]    rem_sh;
  logic              div_ge;
  logic [DEN_W-1:0]  rem_step;
  logic              div_rnd;
  logic [QR_W-1:0]   lim;
  logic [QR_W-1:0]   sat_mag;
  logic [GAIN_W-1:0] sat_val;
  logic              emit_go;

  logic [ACC_W-1:0]  sx_ext;
  logic [ACC_W-1:0]  sy_ext;
  logic [ACC_W-1:0]  sxy_ext;
  logic [ACC_W-1:0]  sxx_ext;
  logic [ACC_W-1:0]  gain_ext;
  logic [ACC_W-1:0]  off_init;

  // operand extensions
  assign sx_ext   = ACC_W'(sum_readings);
  assign sxx_ext  = ACC_W'(sum_squares);
  assign sy_ext   = {{(ACC_W-SY_W){sum_true[SY_W-1]}}, sum_true};
  assign sxy_ext  = {{(ACC_W-SXY_W){sum_products[SXY_W-1]}}, sum_products};
  assign gain_ext = {{(ACC_W-GAIN_W){gain_reg[GAIN_W-1]}}, gain_reg};
  assign off_init = {{(ACC_W-OFFS_W-FRAC_SHIFT){offset_reg[OFFS_W-1]}}, offset_reg,
                     {FRAC_SHIFT{1'b0}}};

  // one radix-8 digit of multiplier times the shifted multiplicand
  always_comb begin
    pp = (mplier[0] ? mcand : '0)
       + (mplier[1] ? {mcand[ACC_W-2:0], 1'b0} : '0)
       + (mplier[2] ? {mcand[ACC_W-3:0], 2'b0} : '0);
    acc_step = acc + pp;
    sq_pp = (mplier[0] ? sq_cand : '0)
          + (mplier[1] ? {sq_cand[SQ_W-2:0], 1'b0} : '0)
          + (mplier[2] ? {sq_cand[SQ_W-3:0], 2'b0} : '0);
    sq_step = sq_acc + sq_pp;
  end

  // magnitude of the accumulator
  assign mag = acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;

  // one restoring division step
  always_comb begin
    rem_sh   = {rem, num_sh[NUM_W-1]};
    div_ge   = rem_sh >= {1'b0, den};
    rem_step = div_ge ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
    div_rnd  = {rem, 1'b0} >= {1'b0, den};
  end

  // saturate the rounded magnitude and apply the sign
  always_comb begin
    lim = (target == TGT_GAIN) ? (QR_W'(1) << (GAIN_W - 1)) : (QR_W'(1) << (OFFS_W - 1));
    if (neg_r) begin
      sat_mag = (qr > lim) ? lim : qr;
    end else begin
      sat_mag = (qr >= lim) ? (lim - QR_W'(1)) : qr;
    end
    sat_val = neg_r ? (GAIN_W'(0) - sat_mag[GAIN_W-1:0]) : sat_mag[GAIN_W-1:0];
  end

  assign emit_go   = (state == S_EMIT) && (!rsp_valid || !rsp_stall);
  assign req_stall = (state != S_IDLE);

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      rsp_valid       <= 1'b0;
      point_tally     <= '0;
      sum_readings    <= '0;
      sum_true        <= '0;
      sum_products    <= '0;
      sum_squares     <= '0;
      gain_reg        <= GAIN_ONE;
      offset_reg      <= '0;
      calibrated_flag <= 1'b0;
    end else begin
      // drop the output word once taken, unless a new one replaces it
      if (rsp_valid && !rsp_stall && !emit_go) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            kind_r   <= (req.op == OP_APPLY) ? KIND_APPLY : KIND_FIT;
            x_r      <= req.adc_value;
            y_r      <= req.real_value;
            last_r   <= req.last_point;
            status_r <= FIT_OK;
            conv_r   <= '0;
            mplier   <= MPL_W'(req.adc_value);
            sq_cand  <= SQ_W'(req.adc_value);
            sq_acc   <= '0;
            steps    <= STEP_W'(ADC_STEPS);
            if (req.op == OP_APPLY) begin
              acc     <= off_init;
              mcand   <= gain_ext;
              mul_ret <= S_AMAG;
              state   <= S_MUL;
            end else begin
              acc   <= '0;
              mcand <= {{(ACC_W-REAL_W){req.real_value[REAL_W-1]}}, req.real_value};
              if (point_tally < TALLY_W'(MAX_POINTS)) begin
                mul_ret <= S_PSUM;
                state   <= S_MUL;
              end else if (req.last_point) begin
                state <= S_FIT;
              end
            end
          end
        end

        // advance the multiplier by one digit
        S_MUL: begin
          acc     <= acc_step;
          sq_acc  <= sq_step;
          mcand   <= {mcand[ACC_W-1-DIGIT_W:0], {DIGIT_W{1'b0}}};
          sq_cand <= {sq_cand[SQ_W-1-DIGIT_W:0], {DIGIT_W{1'b0}}};
          mplier  <= mplier >> DIGIT_W;
          steps   <= steps - STEP_W'(1);
          if (steps == STEP_W'(1)) begin
            state <= mul_ret;
          end
        end

        // fold the point into the sums
        S_PSUM: begin
          point_tally  <= point_tally + TALLY_W'(1);
          sum_readings <= sum_readings + SX_W'(x_r);
          sum_true     <= sum_true + {{(SY_W-REAL_W){y_r[REAL_W-1]}}, y_r};
          sum_products <= sum_products + acc[SXY_W-1:0];
          sum_squares  <= sum_squares + SXX_W'(sq_acc);
          state        <= last_r ? S_FIT : S_IDLE;
        end

        // report too few points, else start the denominator with n * sum x squared
        S_FIT: begin
          if (point_tally < TALLY_W'(2)) begin
            status_r <= FIT_TOO_FEW;
            state    <= S_EMIT;
          end else begin
            acc     <= '0;
            mcand   <= sxx_ext;
            mplier  <= MPL_W'(point_tally);
            steps   <= STEP_W'(TALLY_STEPS);
            mul_ret <= S_DEN;
            state   <= S_MUL;
          end
        end

        // subtract sum x squared
        S_DEN: begin
          mcand   <= ACC_W'(0) - sx_ext;
          mplier  <= MPL_W'(sum_readings);
          steps   <= STEP_W'(SX_STEPS);
          mul_ret <= S_DCHK;
          state   <= S_MUL;
        end

        // fall back on a flat spread, else start the gain numerator
        S_DCHK: begin
          if (acc[ACC_W-1] || (acc == '0)) begin
            gain_reg   <= GAIN_ONE;
            offset_reg <= '0;
            status_r   <= FIT_DEGENERATE;
            state      <= S_EMIT;
          end else begin
            den     <= acc[DEN_W-1:0];
            acc     <= '0;
            mcand   <= sxy_ext;
            mplier  <= MPL_W'(point_tally);
            steps   <= STEP_W'(TALLY_STEPS);
            mul_ret <= S_GNUM;
            state   <= S_MUL;
          end
        end

        S_GNUM: begin
          mcand   <= ACC_W'(0) - sy_ext;
          mplier  <= MPL_W'(sum_readings);
          steps   <= STEP_W'(SX_STEPS);
          mul_ret <= S_GMAG;
          state   <= S_MUL;
        end

        // load the divider with the gain numerator scaled to Q40
        S_GMAG: begin
          neg_r   <= acc[ACC_W-1];
          num_sh  <= {mag[NUM_W-FRAC_SHIFT-1:0], {FRAC_SHIFT{1'b0}}};
          rem     <= '0;
          div_cnt <= CNT_W'(NUM_W);
          target  <= TGT_GAIN;
          state   <= S_DIV;
        end

        S_ONUM: begin
          mcand   <= ACC_W'(0) - sxy_ext;
          mplier  <= MPL_W'(sum_readings);
          steps   <= STEP_W'(SX_STEPS);
          mul_ret <= S_OMAG;
          state   <= S_MUL;
        end

        S_OMAG: begin
          neg_r   <= acc[ACC_W-1];
          num_sh  <= NUM_W'(mag);
          rem     <= '0;
          div_cnt <= CNT_W'(NUM_W);
          target  <= TGT_OFFSET;
          state   <= S_DIV;
        end

        // split the applied sum into integer part and rounding bit
        S_AMAG: begin
          neg_r  <= acc[ACC_W-1];
          num_sh <= NUM_W'(mag[ACC_W-1:FRAC_SHIFT]);
          rnd_r  <= mag[FRAC_SHIFT-1];
          target <= TGT_CONV;
          state  <= S_ROUND;
        end

        // shift one quotient bit in
        S_DIV: begin
          rem     <= rem_step;
          num_sh  <= {num_sh[NUM_W-2:0], div_ge};
          div_cnt <= div_cnt - CNT_W'(1);
          if (div_cnt == CNT_W'(1)) begin
            state <= S_ROUND;
          end
        end

        // round half away from zero on the magnitude
        S_ROUND: begin
          qr    <= {1'b0, num_sh} + QR_W'((target == TGT_CONV) ? rnd_r : div_rnd);
          state <= S_SAT;
        end

        S_SAT: begin
          unique case (target)
            TGT_GAIN: begin
              gain_reg <= sat_val;
              acc      <= '0;
              mcand    <= sy_ext;
              mplier   <= sum_squares;
              steps    <= STEP_W'(SXX_STEPS);
              mul_ret  <= S_ONUM;
              state    <= S_MUL;
            end
            TGT_OFFSET: begin
              offset_reg      <= sat_val[OFFS_W-1:0];
              calibrated_flag <= 1'b1;
              status_r        <= FIT_OK;
              state           <= S_EMIT;
            end
            default: begin
              conv_r <= sat_val[OFFS_W-1:0];
              state  <= S_EMIT;
            end
          endcase
        end

        // hand the result word over and close the session after a report
        S_EMIT: begin
          if (emit_go) begin
            rsp_valid           <= 1'b1;
            rsp.result_kind     <= kind_r;
            rsp.fitted_gain     <= gain_reg;
            rsp.fitted_offset   <= offset_reg;
            rsp.fit_status      <= status_r;
            rsp.is_calibrated   <= calibrated_flag;
            rsp.converted_value <= conv_r;
            if (kind_r == KIND_FIT) begin
              point_tally  <= '0;
              sum_readings <= '0;
              sum_true     <= '0;
              sum_products <= '0;
              sum_squares  <= '0;
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `LSLC_ASSERT_IMPL(a_rem_below_den, clk, rst, state == S_DIV, rem < den, "remainder not below divisor")
  `LSLC_ASSERT_IMPL(a_sum_under_max, clk, rst, state == S_PSUM, point_tally < TALLY_W'(MAX_POINTS), "point summed past the maximum")
  `LSLC_ASSERT_IMPL(a_fit_calibrated, clk, rst, rsp_valid && rsp.result_kind == KIND_FIT && rsp.fit_status == FIT_OK, rsp.is_calibrated, "fitted report without calibrated flag")
  `LSLC_ASSERT_NEXT(a_session_clear, clk, rst, emit_go && kind_r == KIND_FIT, point_tally == '0 && sum_squares == '0, "sums not cleared after report")

endmodule

FILE: tb/tb_least_squares_line_calibrator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the least-squares line calibrator
// Feeds calibration sessions and apply words through the valid/stall ports.
// It keeps its own copy of the sums and the fitted line, predicts every fit
// report and conversion in exact wide arithmetic, and checks each response
// word field by field against the oldest prediction. The run covers random
// idling on both sides, a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_least_squares_line_calibrator;
  import lslc_pkg::*;

  localparam int     CYCLE_LIMIT  = 2000000;
  localparam int     DRAIN_CYCLES = 300;
  localparam int     HOLD_CYCLES  = 800;
  localparam int     RANDOM_WORDS = 1350;
  localparam longint Q16_MAX      = 64'sd2147483647;
  localparam longint Q16_MIN      = -64'sd2147483648;

  typedef struct {
    lslc_req_t word;
    bit        drain;
  } cal_entry_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  lslc_req_t req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b1;
  lslc_rsp_t rsp;

  cal_entry_t cal_words[$];
  lslc_rsp_t  due_reports[$];
  lslc_rsp_t  want;

  int total_words = 0;
  int n_taken     = 0;
  int n_fail      = 0;
  int n_cycles    = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  bit req_took    = 1'b0;

  // running sums and fitted line of the current session
  int                       n_pts    = 0;
  longint                   sx       = 0;
  longint                   sy       = 0;
  longint                   sxy      = 0;
  longint                   sxx      = 0;
  logic signed [GAIN_W-1:0] gain_q40 = GAIN_ONE;
  logic signed [OFFS_W-1:0] offs_q16 = '0;
  bit                       cal_done = 1'b0;

  least_squares_line_calibrator u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // idle percentage per side for the current third of the run
  function int idle_share(input bit sender);
    if (n_taken < total_words / 3) return sender ? 24 : 67;
    if (n_taken < 2 * total_words / 3) return sender ? 67 : 24;
    return 0;
  endfunction

  // divide, round half away from zero, saturate to a signed width
  function automatic logic [63:0] round_div_sat(input logic signed [127:0] num,
                                                input logic [127:0] den,
                                                input int bits);
    logic [127:0] mag, q, r, lim;
    mag = num[127] ? -num : num;
    q   = mag / den;
    r   = mag % den;
    if (r >= den - r) q = q + 1;
    lim = 128'd1 << (bits - 1);
    if (num[127]) begin
      if (q > lim) q = lim;
      q = -q;
    end else if (q > lim - 1) begin
      q = lim - 1;
    end
    return q[63:0];
  endfunction

  // update the session and the line for one accepted word, queue its report
  task automatic advance_line_fit(input lslc_req_t w);
    lslc_rsp_t           r;
    logic signed [127:0] w_n, w_sx, w_sy, w_sxy, w_sxx, w_val, num;
    logic [127:0]        den;
    logic [63:0]         q;
    r = '0;
    if (w.op == OP_POINT) begin
      // drop points once the tally is full
      if (n_pts < MAX_POINTS) begin
        n_pts = n_pts + 1;
        sx    = sx + longint'(w.adc_value);
        sy    = sy + longint'(w.real_value);
        sxy   = sxy + longint'(w.adc_value) * longint'(w.real_value);
        sxx   = sxx + longint'(w.adc_value) * longint'(w.adc_value);
      end
      if (!w.last_point) return;
      r.result_kind = KIND_FIT;
      if (n_pts < 2) begin
        r.fit_status = FIT_TOO_FEW;
      end else if (longint'(n_pts) * sxx <= sx * sx) begin
        // all readings equal: fall back to the unity line
        gain_q40     = GAIN_ONE;
        offs_q16     = '0;
        r.fit_status = FIT_DEGENERATE;
      end else begin
        w_n   = n_pts;
        w_sx  = sx;
        w_sy  = sy;
        w_sxy = sxy;
        w_sxx = sxx;
        den   = longint'(n_pts) * sxx - sx * sx;
        num   = (w_n * w_sxy - w_sx * w_sy) <<< FRAC_SHIFT;
        q     = round_div_sat(num, den, GAIN_W);
        gain_q40 = q;
        num   = w_sy * w_sxx - w_sx * w_sxy;
        q     = round_div_sat(num, den, OFFS_W);
        offs_q16 = q[OFFS_W-1:0];
        cal_done = 1'b1;
        r.fit_status = FIT_OK;
      end
      // start a fresh session after every report
      n_pts = 0;
      sx    = 0;
      sy    = 0;
      sxy   = 0;
      sxx   = 0;
    end else begin
      r.result_kind = KIND_APPLY;
      w_val = gain_q40;
      w_sx  = w.adc_value;
      w_sy  = offs_q16;
      num   = w_val * w_sx + (w_sy <<< FRAC_SHIFT);
      q     = round_div_sat(num, 128'd1 << FRAC_SHIFT, OFFS_W);
      r.converted_value = q[OFFS_W-1:0];
    end
    r.fitted_gain   = gain_q40;
    r.fitted_offset = offs_q16;
    r.is_calibrated = cal_done;
    due_reports.push_back(r);
  endtask

  // queue one request word, clamping the true value to Q15.16
  task automatic push_word(input logic op, input int x, input longint y,
                           input logic last, input bit drain = 1'b0);
    cal_entry_t e;
    if (y > Q16_MAX) y = Q16_MAX;
    else if (y < Q16_MIN) y = Q16_MIN;
    e.word.op         = op;
    e.word.adc_value  = x[ADC_W-1:0];
    e.word.real_value = y[REAL_W-1:0];
    e.word.last_point = last;
    e.drain           = drain;
    cal_words.push_back(e);
  endtask

  // stimulus, reset and end of run
  initial begin
    int kind, npts, slope, icpt, base_x, x;

    // reset line, too few points, degenerate spread
    push_word(OP_APPLY, 0, 0, 1'b0);
    push_word(OP_APPLY, 4095, -1, 1'b1);
    push_word(OP_POINT, 123, 5, 1'b1);
    push_word(OP_POINT, 100, 1, 1'b0);
    push_word(OP_POINT, 100, 7, 1'b1);
    // steepest rising line: offset saturates low
    push_word(OP_POINT, 4094, Q16_MIN, 1'b0);
    push_word(OP_POINT, 4095, Q16_MAX, 1'b1);
    push_word(OP_APPLY, 4095, 0, 1'b0);
    push_word(OP_APPLY, 0, 0, 1'b0);
    push_word(OP_APPLY, 1, 0, 1'b0);
    // steepest falling line: offset saturates high
    push_word(OP_POINT, 4094, Q16_MAX, 1'b0);
    push_word(OP_POINT, 4095, Q16_MIN, 1'b1);
    push_word(OP_APPLY, 4095, 0, 1'b0);
    push_word(OP_APPLY, 4094, 0, 1'b0);
    // ordinary three-point fit
    push_word(OP_POINT, 0, 0, 1'b0);
    push_word(OP_POINT, 2048, 32'h0001_0000, 1'b0);
    push_word(OP_POINT, 4095, 32'h0002_0000, 1'b1);
    push_word(OP_APPLY, 1000, 0, 1'b0);
    push_word(OP_APPLY, 4095, 0, 1'b0);
    // degenerate and too few after a good fit
    push_word(OP_POINT, 0, Q16_MAX, 1'b0);
    push_word(OP_POINT, 0, Q16_MIN, 1'b1);
    push_word(OP_APPLY, 4095, 0, 1'b0);
    push_word(OP_POINT, 7, 0, 1'b1);

    // full session, then one that overruns the tally
    slope = int'($urandom_range(0, 524288)) - 262144;
    icpt  = int'($urandom_range(0, 1 << 30)) - (1 << 29);
    for (int i = 1; i <= MAX_POINTS; i++) begin
      x = $urandom_range(0, 4095);
      push_word(OP_POINT, x, longint'(slope) * x + icpt, i == MAX_POINTS, i == 1);
    end
    push_word(OP_APPLY, $urandom_range(0, 4095), 0, 1'b0);
    for (int i = 1; i <= MAX_POINTS + 5; i++) begin
      x = $urandom_range(0, 4095);
      push_word(OP_POINT, x, longint'(-slope) * x - icpt + int'($urandom_range(0, 4096)),
                i == MAX_POINTS + 5);
    end

    // random sessions, applies and noise
    while (cal_words.size() < RANDOM_WORDS + 23) begin
      kind   = $urandom_range(0, 99);
      slope  = int'($urandom_range(0, 524288)) - 262144;
      icpt   = int'($urandom_range(0, 1 << 30)) - (1 << 29);
      base_x = $urandom_range(0, 4095);
      if (kind < 50) begin
        npts = $urandom_range(2, 12);
        for (int i = 1; i <= npts; i++) begin
          x = (kind < 10) ? (base_x & 12'hff0) + int'($urandom_range(0, 15))
                          : int'($urandom_range(0, 4095));
          push_word(OP_POINT, x,
                    longint'(slope) * x + icpt + int'($urandom_range(0, 512)) - 256,
                    i == npts, i == 1 && $urandom_range(0, 24) == 0);
        end
        repeat ($urandom_range(0, 4))
          push_word(OP_APPLY, $urandom_range(0, 4095), int'($urandom), $urandom_range(0, 1));
      end else if (kind < 65) begin
        repeat ($urandom_range(1, 5))
          push_word(OP_APPLY, $urandom_range(0, 4095), int'($urandom), $urandom_range(0, 1));
      end else if (kind < 78) begin
        push_word($urandom_range(0, 1), $urandom_range(0, 4095), int'($urandom),
                  $urandom_range(0, 3) == 0);
      end else if (kind < 84) begin
        push_word(OP_POINT, base_x, int'($urandom), 1'b1);
      end else if (kind < 92) begin
        npts = $urandom_range(2, 6);
        for (int i = 1; i <= npts; i++)
          push_word(OP_POINT, base_x, int'($urandom), i == npts);
      end else begin
        npts = $urandom_range(2, 4);
        for (int i = 1; i <= npts; i++)
          push_word(OP_POINT, $urandom_range(0, 1) ? 4095 : 0,
                    $urandom_range(0, 1) ? Q16_MAX : Q16_MIN, i == npts);
        push_word(OP_APPLY, $urandom_range(0, 1) ? 4095 : 0, 0, 1'b0);
      end
    end
    total_words = cal_words.size();

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // wait for every word to go in and every report to come out
    while (n_taken < total_words || due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // note each accepted request word and predict its report
  always @(posedge clk) begin
    req_took = !rst && req_valid && !req_stall;
    if (req_took) begin
      advance_line_fit(req);
      n_taken++;
    end
  end

  // present the next word; hold a stalled one, pause for a drain where marked
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_took) begin
      if (cal_words.size() != 0 && !(cal_words[0].drain && due_reports.size() != 0) &&
          $urandom_range(0, 99) >= idle_share(1'b1)) begin
        req       <= cal_words[0].word;
        req_valid <= 1'b1;
        cal_words.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // hold off the receiver once, late in the run, while words keep coming
  always @(negedge clk) begin
    if (!hold_done && total_words != 0 && n_taken >= 5 * total_words / 6) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver stall
  always @(negedge clk) begin
    rsp_stall <= (hold_left > 0) || ($urandom_range(0, 99) < idle_share(1'b0));
  end

  // compare each response word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (due_reports.size() == 0) begin
        $error("response word with nothing predicted");
        n_fail++;
      end else begin
        want = due_reports.pop_front();
        if (rsp.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, got %0d", want.result_kind, rsp.result_kind);
          n_fail++;
        end
        if (rsp.fitted_gain !== want.fitted_gain) begin
          $error("fitted_gain: expected %0d, got %0d", want.fitted_gain, rsp.fitted_gain);
          n_fail++;
        end
        if (rsp.fitted_offset !== want.fitted_offset) begin
          $error("fitted_offset: expected %0d, got %0d", want.fitted_offset,
                 rsp.fitted_offset);
          n_fail++;
        end
        if (rsp.fit_status !== want.fit_status) begin
          $error("fit_status: expected %0d, got %0d", want.fit_status, rsp.fit_status);
          n_fail++;
        end
        if (rsp.is_calibrated !== want.is_calibrated) begin
          $error("is_calibrated: expected %0d, got %0d", want.is_calibrated,
                 rsp.is_calibrated);
          n_fail++;
        end
        if (rsp.converted_value !== want.converted_value) begin
          $error("converted_value: expected %0d, got %0d", want.converted_value,
                 rsp.converted_value);
          n_fail++;
        end
      end
    end
  end

  // end a hung run
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
